// ----- design/onbmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// onbmsd_pkg
// Shared constants, types and tables for the order-n block MSD correlator.
// ----------------------------------------------------------------------------
package onbmsd_pkg;

    localparam int NUM_BLOCKS     = 8;
    localparam int BLOCK_ELEMENTS = 10;
    localparam int NCOMP          = 6;

    localparam int ROWS    = NUM_BLOCKS * BLOCK_ELEMENTS;
    localparam int ENTRIES = ROWS * NCOMP;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int ENT_W   = $clog2(ENTRIES);
    localparam int BLK_W   = $clog2(NUM_BLOCKS + 1);
    localparam int BIDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int FILL_W  = $clog2(BLOCK_ELEMENTS + 1);
    localparam int K_W     = $clog2(BLOCK_ELEMENTS);
    localparam int DIG_W   = $clog2(BLOCK_ELEMENTS);
    localparam int COMP_W  = 3;
    localparam int PER_W   = 41;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_MIDDLE = 2'd1;
    localparam logic [1:0] PH_END    = 2'd2;

    typedef logic [NUM_BLOCKS:0][PER_W-1:0] t_period_tab;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INTEG,
        ST_GROW,
        ST_BLK,
        ST_SQ_RD,
        ST_SQ_DIF,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SH_RD,
        ST_SH_WR,
        ST_TOP,
        ST_RD,
        ST_LOAD,
        ST_OUT
    } t_state;

    // Block periods BLOCK_ELEMENTS^e, held at 2^40 once beyond any 32-bit count.
    function automatic t_period_tab f_period_tab();
        t_period_tab        tab;
        logic [PER_W+5:0]   p;
        p = (PER_W+6)'(1);
        for (int e = 0; e <= NUM_BLOCKS; e++) begin
            tab[e] = p[PER_W-1:0];
            p = p * (PER_W+6)'(BLOCK_ELEMENTS);
            if (p > ((PER_W+6)'(1) << 40)) begin
                p = (PER_W+6)'(1) << 40;
            end
        end
        return tab;
    endfunction

    localparam t_period_tab PERIOD_TAB = f_period_tab();

endpackage

// ----- design/order_n_block_msd_correlator_top.sv -----
// ----------------------------------------------------------------------------
// order_n_block_msd_correlator_top
// Order-n multiple-tau mean-squared-displacement correlator for heat flux.
// ----------------------------------------------------------------------------
// A beat with tuser 0 carries a six-component flux sample; samples are grouped
// as first, middle and end, and every end sample closes a Simpson interval,
// adds the unscaled sum (a + 4c + b) to the running integrals and updates the
// correlator. A beat with tuser 1 reads one entry and yields one output beat
// holding its saturating squared sum and its count. The block is not ready
// while it works on a beat. Closing an interval integrates each component in
// turn, may grow the number of active blocks, and for each due block passes
// every filled element and component through the single subtract, square
// and accumulate unit, shifts the history down one element and stores the
// new integral at the top. A read passes through a store read and a load
// step before its output beat. Scaling by (dt/3)^2, volume and Boltzmann
// factors is left to software. Stores come out of reset empty, tracked per
// row by valid bits, so no clearing pass is needed.
module order_n_block_msd_correlator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // flux_total_x, flux_total_y, flux_total_z, flux_conv_x, flux_conv_y,
    // flux_conv_z (24 each), read_block (3), read_element (4),
    // read_component (3), zero padding (6)
    input  logic [159:0] s_axis_tdata,
    // action (1)
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // squared_sum (64), sample_total (32)
    output logic [95:0]  m_axis_tdata
);

    localparam int NB  = onbmsd_pkg::NUM_BLOCKS;
    localparam int BE  = onbmsd_pkg::BLOCK_ELEMENTS;
    localparam int NC  = onbmsd_pkg::NCOMP;
    localparam int RW  = onbmsd_pkg::ROW_W;
    localparam int EW  = onbmsd_pkg::ENT_W;
    localparam int BW  = onbmsd_pkg::BLK_W;
    localparam int BIW = onbmsd_pkg::BIDX_W;
    localparam int FW  = onbmsd_pkg::FILL_W;
    localparam int KW  = onbmsd_pkg::K_W;
    localparam int DW  = onbmsd_pkg::DIG_W;
    localparam int CW  = onbmsd_pkg::COMP_W;
    localparam int ROWS_M1 = onbmsd_pkg::ROWS - 1;

    onbmsd_pkg::t_state r_state, n_state;

    logic [1:0]         r_phase;
    logic signed [23:0] r_first [NC];
    logic signed [23:0] r_mid   [NC];
    logic signed [23:0] r_end   [NC];
    logic [47:0]        r_run   [NC];
    logic [31:0]        r_ic;
    logic [DW-1:0]      r_digit [NB];
    logic [BW-1:0]      r_active;
    logic [FW-1:0]      r_fill  [NB];
    logic [BW-1:0]      r_b;
    logic [KW-1:0]      r_k;
    logic [CW-1:0]      r_c;
    logic [ROWS_M1:0]   r_past_valid;
    logic [ROWS_M1:0]   r_sq_valid;

    logic [47:0] m_past [onbmsd_pkg::ENTRIES];
    logic [63:0] m_sq   [onbmsd_pkg::ENTRIES];
    logic [31:0] m_cnt  [onbmsd_pkg::ROWS];

    logic [47:0] r_past_q;
    logic [63:0] r_sq_q;
    logic [31:0] r_cnt_q;
    logic        r_past_ok;
    logic        r_sq_ok;
    logic [31:0] r_mag;
    logic        r_big;
    logic [63:0] r_sq;
    logic        r_rd_bad;
    logic [RW-1:0] r_rd_row;
    logic [EW-1:0] r_rd_ent;
    logic [63:0] r_out_sum;
    logic [31:0] r_out_cnt;

    logic          w_accept;
    logic          w_last_c;
    logic          w_last_k;
    logic          w_due;
    logic [RW-1:0] w_row;
    logic [RW-1:0] w_row_prev;
    logic [EW-1:0] w_ent;
    logic [EW-1:0] w_ent_prev;
    logic [RW-1:0] w_rd_row;
    logic [EW-1:0] w_rd_ent;
    logic [47:0]   w_simp;
    logic [47:0]   w_past;
    logic [47:0]   w_diff;
    logic [47:0]   w_mag;
    logic [63:0]   w_prod;
    logic [64:0]   w_acc;
    logic [63:0]   w_old_sq;
    logic [31:0]   w_old_cnt;
    logic [31:0]   w_in_row;
    logic [BIW-1:0] w_bi;

    assign s_axis_tready = (r_state == onbmsd_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == onbmsd_pkg::ST_OUT);
    assign m_axis_tdata  = {r_out_cnt, r_out_sum};
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_last_c   = (r_c == CW'(NC - 1));
    assign w_last_k   = (r_k == KW'(BE - 1));
    assign w_bi       = r_b[BIW-1:0];
    assign w_row      = RW'(r_b) * RW'(BE) + RW'(r_k);
    assign w_row_prev = w_row - RW'(1);
    assign w_ent      = EW'(w_row) * EW'(NC) + EW'(r_c);
    assign w_ent_prev = EW'(w_row_prev) * EW'(NC) + EW'(r_c);
    assign w_rd_row   = (r_state == onbmsd_pkg::ST_RD) ? r_rd_row : w_row;
    assign w_rd_ent   = (r_state == onbmsd_pkg::ST_RD) ? r_rd_ent : w_ent;

    // Block b is due when the low b base-BLOCK_ELEMENTS digits of the count are zero.
    always_comb begin
        w_due = 1'b1;
        for (int i = 0; i < NB; i++) begin
            if ((BW'(i) < r_b) && (r_digit[i] != '0)) begin
                w_due = 1'b0;
            end
        end
    end

    assign w_simp = {{24{r_first[r_c][23]}}, r_first[r_c]}
                  + ({{24{r_mid[r_c][23]}}, r_mid[r_c]} << 2)
                  + {{24{r_end[r_c][23]}}, r_end[r_c]};

    assign w_past    = r_past_ok ? r_past_q : '0;
    assign w_diff    = r_run[r_c] - w_past;
    assign w_mag     = w_diff[47] ? (48'd0 - w_diff) : w_diff;
    assign w_prod    = r_mag * r_mag;
    assign w_old_sq  = r_sq_ok ? r_sq_q : '0;
    assign w_old_cnt = r_sq_ok ? r_cnt_q : '0;
    assign w_acc     = {1'b0, w_old_sq} + {1'b0, r_sq};
    assign w_in_row  = 32'(s_axis_tdata[146:144]) * 32'(BE) + 32'(s_axis_tdata[150:147]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= onbmsd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            onbmsd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser[0] == onbmsd_pkg::ACT_READ) begin
                        n_state = onbmsd_pkg::ST_RD;
                    end else if (r_phase != onbmsd_pkg::PH_FIRST &&
                                 r_phase != onbmsd_pkg::PH_MIDDLE) begin
                        n_state = onbmsd_pkg::ST_INTEG;
                    end
                end
            end
            onbmsd_pkg::ST_INTEG: if (w_last_c) n_state = onbmsd_pkg::ST_GROW;
            onbmsd_pkg::ST_GROW:  n_state = onbmsd_pkg::ST_BLK;
            onbmsd_pkg::ST_BLK: begin
                if (r_b >= r_active) begin
                    n_state = onbmsd_pkg::ST_IDLE;
                end else if (w_due) begin
                    n_state = onbmsd_pkg::ST_SQ_RD;
                end
            end
            onbmsd_pkg::ST_SQ_RD:  n_state = onbmsd_pkg::ST_SQ_DIF;
            onbmsd_pkg::ST_SQ_DIF: n_state = onbmsd_pkg::ST_SQ_MUL;
            onbmsd_pkg::ST_SQ_MUL: n_state = onbmsd_pkg::ST_SQ_ACC;
            onbmsd_pkg::ST_SQ_ACC: begin
                n_state = (w_last_c && w_last_k) ? onbmsd_pkg::ST_SH_RD
                                                 : onbmsd_pkg::ST_SQ_RD;
            end
            onbmsd_pkg::ST_SH_RD: n_state = onbmsd_pkg::ST_SH_WR;
            onbmsd_pkg::ST_SH_WR: begin
                n_state = (w_last_c && w_last_k) ? onbmsd_pkg::ST_TOP
                                                 : onbmsd_pkg::ST_SH_RD;
            end
            onbmsd_pkg::ST_TOP:  if (w_last_c) n_state = onbmsd_pkg::ST_BLK;
            onbmsd_pkg::ST_RD:   n_state = onbmsd_pkg::ST_LOAD;
            onbmsd_pkg::ST_LOAD: n_state = onbmsd_pkg::ST_OUT;
            onbmsd_pkg::ST_OUT:  if (m_axis_tready) n_state = onbmsd_pkg::ST_IDLE;
            default:             n_state = onbmsd_pkg::ST_IDLE;
        endcase
    end

    // Stores: one read and one write per cycle each, read data registered.
    always_ff @(posedge i_clk) begin
        r_past_q  <= m_past[w_rd_ent];
        r_sq_q    <= m_sq[w_rd_ent];
        r_cnt_q   <= m_cnt[w_rd_row];
        r_past_ok <= r_past_valid[w_rd_row];
        r_sq_ok   <= r_sq_valid[w_rd_row];
        if (r_state == onbmsd_pkg::ST_SH_WR) begin
            m_past[w_ent_prev] <= w_past;
        end else if (r_state == onbmsd_pkg::ST_TOP) begin
            m_past[w_ent] <= r_run[r_c];
        end
        if (r_state == onbmsd_pkg::ST_SQ_ACC) begin
            m_sq[w_ent] <= w_acc[64] ? '1 : w_acc[63:0];
            if (w_last_c) begin
                m_cnt[w_row] <= (w_old_cnt == '1) ? w_old_cnt : w_old_cnt + 32'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == onbmsd_pkg::ST_IDLE && w_accept) begin
            for (int i = 0; i < NC; i++) begin
                r_end[i] <= s_axis_tdata[24*i +: 24];
            end
            r_rd_bad <= (32'(s_axis_tdata[146:144]) >= 32'(NB))
                     || (32'(s_axis_tdata[150:147]) >= 32'(BE))
                     || (32'(s_axis_tdata[153:151]) >= 32'(NC));
            r_rd_row <= w_in_row[RW-1:0];
            r_rd_ent <= EW'(w_in_row[RW-1:0]) * EW'(NC) + EW'(s_axis_tdata[153:151]);
        end
        if (r_state == onbmsd_pkg::ST_SQ_DIF) begin
            r_mag <= w_mag[31:0];
            r_big <= (w_mag[47:32] != '0);
        end
        if (r_state == onbmsd_pkg::ST_SQ_MUL) begin
            r_sq <= r_big ? '1 : w_prod;
        end
        if (r_state == onbmsd_pkg::ST_LOAD) begin
            r_out_sum <= (r_rd_bad || !r_sq_ok) ? '0 : r_sq_q;
            r_out_cnt <= (r_rd_bad || !r_sq_ok) ? '0 : r_cnt_q;
        end
    end

    // Control and correlator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= onbmsd_pkg::PH_FIRST;
            r_ic         <= 32'd1;
            r_active     <= BW'(1);
            r_b          <= '0;
            r_k          <= '0;
            r_c          <= '0;
            r_past_valid <= '0;
            r_sq_valid   <= '0;
            for (int i = 0; i < NB; i++) begin
                r_digit[i] <= (i == 0) ? DW'(1) : '0;
                r_fill[i]  <= FW'(1);
            end
            for (int i = 0; i < NC; i++) begin
                r_first[i] <= '0;
                r_mid[i]   <= '0;
                r_run[i]   <= '0;
            end
        end else begin
            unique case (r_state)
                onbmsd_pkg::ST_IDLE: begin
                    if (w_accept && s_axis_tuser[0] == onbmsd_pkg::ACT_SAMPLE) begin
                        r_c <= '0;
                        if (r_phase == onbmsd_pkg::PH_FIRST) begin
                            for (int i = 0; i < NC; i++) begin
                                r_first[i] <= s_axis_tdata[24*i +: 24];
                                r_run[i]   <= '0;
                            end
                            r_past_valid <= '0;
                            r_sq_valid   <= '0;
                            r_phase      <= onbmsd_pkg::PH_MIDDLE;
                        end else if (r_phase == onbmsd_pkg::PH_MIDDLE) begin
                            for (int i = 0; i < NC; i++) begin
                                r_mid[i] <= s_axis_tdata[24*i +: 24];
                            end
                            r_phase <= onbmsd_pkg::PH_END;
                        end
                    end
                end
                onbmsd_pkg::ST_INTEG: begin
                    r_run[r_c]   <= r_run[r_c] + w_simp;
                    r_first[r_c] <= r_end[r_c];
                    r_mid[r_c]   <= '0;
                    r_c          <= w_last_c ? '0 : r_c + CW'(1);
                    if (w_last_c) begin
                        r_phase <= onbmsd_pkg::PH_MIDDLE;
                    end
                end
                onbmsd_pkg::ST_GROW: begin
                    if (r_active < BW'(NB) &&
                        {9'd0, r_ic} >= onbmsd_pkg::PERIOD_TAB[r_active]) begin
                        r_active <= r_active + BW'(1);
                    end
                    r_b <= '0;
                end
                onbmsd_pkg::ST_BLK: begin
                    r_c <= '0;
                    if (r_b >= r_active) begin
                        // Interval closed: advance the count and its digits.
                        r_ic <= r_ic + 32'd1;
                        if (r_ic == '1) begin
                            for (int i = 0; i < NB; i++) r_digit[i] <= '0;
                        end else begin
                            for (int i = 0; i < NB; i++) begin
                                automatic logic carry = 1'b1;
                                for (int j = 0; j < i; j++) begin
                                    if (r_digit[j] != DW'(BE - 1)) carry = 1'b0;
                                end
                                if (carry) begin
                                    r_digit[i] <= (r_digit[i] == DW'(BE - 1))
                                                ? '0 : r_digit[i] + DW'(1);
                                end
                            end
                        end
                    end else if (w_due) begin
                        r_k <= KW'(BE) - KW'(r_fill[w_bi]);
                    end else begin
                        r_b <= r_b + BW'(1);
                    end
                end
                onbmsd_pkg::ST_SQ_ACC: begin
                    if (w_last_c) begin
                        r_sq_valid[w_row] <= 1'b1;
                        r_c <= '0;
                        if (w_last_k) begin
                            r_k <= KW'(1);
                            if (r_fill[w_bi] < FW'(BE)) begin
                                r_fill[w_bi] <= r_fill[w_bi] + FW'(1);
                            end
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end else begin
                        r_c <= r_c + CW'(1);
                    end
                end
                onbmsd_pkg::ST_SH_WR: begin
                    if (w_last_c) begin
                        r_past_valid[w_row_prev] <= 1'b1;
                        r_c <= '0;
                        if (!w_last_k) r_k <= r_k + KW'(1);
                    end else begin
                        r_c <= r_c + CW'(1);
                    end
                end
                onbmsd_pkg::ST_TOP: begin
                    if (w_last_c) begin
                        r_past_valid[w_row] <= 1'b1;
                        r_c <= '0;
                        r_b <= r_b + BW'(1);
                    end else begin
                        r_c <= r_c + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- bench/tb_order_n_block_msd_correlator_top.sv -----
// ----------------------------------------------------------------------------
// tb_order_n_block_msd_correlator_top
// Self-checking bench for the order-n block MSD correlator.
// ----------------------------------------------------------------------------
// Flux samples and entry reads are pushed into the block through the input
// stream. The bench keeps its own copy of the correlator state. Each read
// beat that is accepted queues the expected squared sum and count. Output
// beats are checked in order against that queue. Both sides of the stream
// pause at random between beats.
// ----------------------------------------------------------------------------
module tb_order_n_block_msd_correlator_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS     = onbmsd_pkg::NUM_BLOCKS;
    localparam int BLOCK_ELEMENTS = onbmsd_pkg::BLOCK_ELEMENTS;
    localparam int NCOMP          = onbmsd_pkg::NCOMP;

    localparam logic [47:0] HALF48 = 48'h8000_0000_0000;

    // One beat for the input stream: the action travels in tuser.
    typedef struct packed {
        logic                   action;
        logic [NCOMP-1:0][23:0] flux;
        logic [2:0]             rd_blk;
        logic [3:0]             rd_el;
        logic [2:0]             rd_comp;
    } flux_beat_t;

    typedef struct {
        logic [63:0] sq_sum;
        logic [31:0] n_sum;
    } entry_read_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;

    order_n_block_msd_correlator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the correlator state.
    logic signed [23:0] grp_first [NCOMP];
    logic signed [23:0] grp_mid   [NCOMP];
    logic [1:0]         grp_phase;
    logic [47:0]        integ     [NCOMP];
    logic [31:0]        n_interval;
    int unsigned        n_active;
    int unsigned        fill      [NUM_BLOCKS];
    logic [47:0]        hist      [NUM_BLOCKS][BLOCK_ELEMENTS][NCOMP];
    logic [63:0]        sq_acc    [NUM_BLOCKS][BLOCK_ELEMENTS][NCOMP];
    logic [31:0]        lag_count [NUM_BLOCKS][BLOCK_ELEMENTS];

    flux_beat_t  pending_beats [$];
    entry_read_t expected_reads [$];
    int          n_errors;
    int          n_reads_seen;
    int          n_samples_sent;

    function automatic logic [63:0] block_period(int unsigned e);
        logic [63:0] p;
        p = 1;
        for (int i = 0; i < e; i++) begin
            p = p * BLOCK_ELEMENTS;
            if (p > 64'h100_0000_0000) begin
                p = 64'h100_0000_0000;
            end
        end
        return p;
    endfunction

    function automatic logic [63:0] clipped_square(logic [47:0] now_v, logic [47:0] old_v);
        logic [47:0] d;
        logic [47:0] mag;
        d = now_v - old_v;
        mag = d[47] ? (48'd0 - d) : d;
        // d = -2^47 negates to itself; its magnitude is still far past 2^32.
        if (d == HALF48 || mag >= 48'h1_0000_0000) begin
            return '1;
        end
        return {16'd0, mag} * {16'd0, mag};
    endfunction

    task automatic clear_store();
        for (int c = 0; c < NCOMP; c++) begin
            integ[c] = '0;
        end
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            for (int k = 0; k < BLOCK_ELEMENTS; k++) begin
                lag_count[b][k] = '0;
                for (int c = 0; c < NCOMP; c++) begin
                    hist[b][k][c]   = '0;
                    sq_acc[b][k][c] = '0;
                end
            end
        end
    endtask

    task automatic shadow_reset();
        for (int c = 0; c < NCOMP; c++) begin
            grp_first[c] = '0;
            grp_mid[c]   = '0;
        end
        grp_phase  = onbmsd_pkg::PH_FIRST;
        n_interval = 32'd1;
        n_active   = 1;
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            fill[b] = 1;
        end
        clear_store();
    endtask

    // Simpson step plus correlator update for one end sample.
    task automatic close_group(logic signed [23:0] endv [NCOMP]);
        logic signed [47:0] simpson;
        logic [63:0]        sq;
        logic [63:0]        t;
        int unsigned        len;
        for (int c = 0; c < NCOMP; c++) begin
            simpson = 48'(grp_first[c]) + 4 * 48'(grp_mid[c]) + 48'(endv[c]);
            integ[c] = integ[c] + simpson;
            grp_first[c] = endv[c];
            grp_mid[c] = '0;
        end
        while (n_active < NUM_BLOCKS && block_period(n_active) <= {32'd0, n_interval}) begin
            n_active++;
        end
        for (int b = 0; b < n_active; b++) begin
            if (({32'd0, n_interval} % block_period(b)) == 0) begin
                len = fill[b];
                for (int k = BLOCK_ELEMENTS - len; k < BLOCK_ELEMENTS; k++) begin
                    for (int c = 0; c < NCOMP; c++) begin
                        sq = clipped_square(integ[c], hist[b][k][c]);
                        t = sq_acc[b][k][c] + sq;
                        sq_acc[b][k][c] = (t < sq) ? '1 : t;
                    end
                    if (lag_count[b][k] != '1) begin
                        lag_count[b][k]++;
                    end
                end
                if (fill[b] < BLOCK_ELEMENTS) begin
                    fill[b]++;
                end
                for (int k = 1; k < BLOCK_ELEMENTS; k++) begin
                    for (int c = 0; c < NCOMP; c++) begin
                        hist[b][k-1][c] = hist[b][k][c];
                    end
                end
                for (int c = 0; c < NCOMP; c++) begin
                    hist[b][BLOCK_ELEMENTS-1][c] = integ[c];
                end
            end
        end
        n_interval++;
    endtask

    task automatic predict_beat(flux_beat_t bt);
        entry_read_t        r;
        logic signed [23:0] v [NCOMP];
        if (bt.action == onbmsd_pkg::ACT_READ) begin
            r.sq_sum = '0;
            r.n_sum  = '0;
            if (bt.rd_blk < NUM_BLOCKS && bt.rd_el < BLOCK_ELEMENTS && bt.rd_comp < NCOMP) begin
                r.sq_sum = sq_acc[bt.rd_blk][bt.rd_el][bt.rd_comp];
                r.n_sum  = lag_count[bt.rd_blk][bt.rd_el];
            end
            expected_reads.push_back(r);
            return;
        end
        for (int c = 0; c < NCOMP; c++) begin
            v[c] = bt.flux[c];
        end
        if (grp_phase == onbmsd_pkg::PH_FIRST) begin
            grp_first = v;
            clear_store();
            grp_phase = onbmsd_pkg::PH_MIDDLE;
        end else if (grp_phase == onbmsd_pkg::PH_MIDDLE) begin
            grp_mid = v;
            grp_phase = onbmsd_pkg::PH_END;
        end else begin
            close_group(v);
            grp_phase = onbmsd_pkg::PH_MIDDLE;
        end
    endtask

    function automatic flux_beat_t sample_beat(int mode);
        flux_beat_t bt;
        bt = '0;
        bt.action = onbmsd_pkg::ACT_SAMPLE;
        for (int c = 0; c < NCOMP; c++) begin
            case (mode)
                0: bt.flux[c] = 24'($urandom_range(0, 4095)) - 24'd2048;
                1: bt.flux[c] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                default: bt.flux[c] = 24'($urandom);
            endcase
        end
        // Random bits in the unused read fields must be ignored.
        bt.rd_blk  = 3'($urandom);
        bt.rd_el   = 4'($urandom);
        bt.rd_comp = 3'($urandom);
        return bt;
    endfunction

    function automatic flux_beat_t read_beat(int blk, int el, int comp);
        flux_beat_t bt;
        bt = '0;
        bt.action  = onbmsd_pkg::ACT_READ;
        for (int c = 0; c < NCOMP; c++) begin
            bt.flux[c] = 24'($urandom);
        end
        bt.rd_blk  = 3'(blk);
        bt.rd_el   = 4'(el);
        bt.rd_comp = 3'(comp);
        return bt;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Input side: one beat at a time from the pending queue, with a random
    // pause drawn after every accepted beat. Burst stretches run unpaused.
    int         src_gap;
    flux_beat_t cur_beat;
    bit         burst_mode;

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        src_gap       = 0;
        burst_mode    = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            predict_beat(cur_beat);
            if (cur_beat.action == onbmsd_pkg::ACT_SAMPLE) begin
                n_samples_sent++;
            end
            if ($urandom_range(0, 99) == 0) begin
                burst_mode = ~burst_mode;
            end
            src_gap = burst_mode ? 0 : $urandom_range(0, 17);
            if (src_gap == 0 && pending_beats.size() != 0) begin
                cur_beat = pending_beats.pop_front();
                s_axis_tdata <= {6'd0, cur_beat.rd_comp, cur_beat.rd_el, cur_beat.rd_blk,
                                 cur_beat.flux[5], cur_beat.flux[4], cur_beat.flux[3],
                                 cur_beat.flux[2], cur_beat.flux[1], cur_beat.flux[0]};
                s_axis_tuser <= cur_beat.action;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end else if (!s_axis_tvalid) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (pending_beats.size() != 0) begin
                cur_beat = pending_beats.pop_front();
                s_axis_tdata <= {6'd0, cur_beat.rd_comp, cur_beat.rd_el, cur_beat.rd_blk,
                                 cur_beat.flux[5], cur_beat.flux[4], cur_beat.flux[3],
                                 cur_beat.flux[2], cur_beat.flux[1], cur_beat.flux[0]};
                s_axis_tuser  <= cur_beat.action;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Output side: ready drops for a random pause after each beat taken.
    int snk_gap;
    initial snk_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_reads_seen++;
                if (expected_reads.size() == 0) begin
                    $display("%0t: unexpected output beat, got sum %h count %h", $time,
                             m_axis_tdata[63:0], m_axis_tdata[95:64]);
                    n_errors++;
                end else begin
                    entry_read_t e;
                    e = expected_reads.pop_front();
                    if (m_axis_tdata[63:0] !== e.sq_sum) begin
                        $display("%0t: squared sum mismatch, expected %h actual %h", $time,
                                 e.sq_sum, m_axis_tdata[63:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[95:64] !== e.n_sum) begin
                        $display("%0t: count mismatch, expected %h actual %h", $time,
                                 e.n_sum, m_axis_tdata[95:64]);
                        n_errors++;
                    end
                end
                snk_gap = burst_mode ? 0 : $urandom_range(0, 17);
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int n_rand;
        int mode;
        n_errors       = 0;
        n_reads_seen   = 0;
        n_samples_sent = 0;
        shadow_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a read before any sample, a few groups of extreme values
        // for large squares, then reads of edge slots and bad addresses.
        pending_beats.push_back(read_beat(0, 9, 0));
        pending_beats.push_back(sample_beat(1));
        for (int i = 0; i < 8; i++) begin
            pending_beats.push_back(sample_beat(i < 4 ? 1 : 0));
        end
        pending_beats.push_back(read_beat(0, 9, 5));
        pending_beats.push_back(read_beat(0, 0, 3));
        pending_beats.push_back(read_beat(7, 9, 2));
        pending_beats.push_back(read_beat(0, 10, 0));
        pending_beats.push_back(read_beat(0, 15, 1));
        pending_beats.push_back(read_beat(2, 5, 6));
        pending_beats.push_back(read_beat(7, 0, 7));
        pending_beats.push_back(read_beat(0, 8, 4));

        // Random part: mostly small-valued samples so the history fills and
        // the second and third blocks become due, with reads sprinkled in.
        n_rand = 0;
        while (n_rand < 1900) begin
            if ($urandom_range(0, 9) < 3) begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_beats.push_back(read_beat($urandom_range(0, 7),
                        $urandom_range(0, 15), $urandom_range(0, 7)));
                end else begin
                    pending_beats.push_back(read_beat($urandom_range(0, 2),
                        $urandom_range(0, 9), $urandom_range(0, 5)));
                end
            end else begin
                mode = $urandom_range(0, 19);
                pending_beats.push_back(sample_beat(mode < 16 ? 0 : (mode < 18 ? 2 : 1)));
            end
            n_rand++;
        end

        wait (pending_beats.size() == 0 && !s_axis_tvalid);
        wait (expected_reads.size() == 0);
        repeat (3000) @(posedge i_clk);
        $display("Sent %0d flux samples (%0d intervals closed) and checked %0d entry reads.",
                 n_samples_sent, n_interval - 1, n_reads_seen);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: fails the run if the stimulus has not finished by the time limit.
    initial begin
        #(4ns * 30_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
design/onbmsd_pkg.sv
design/order_n_block_msd_correlator_top.sv
bench/tb_order_n_block_msd_correlator_top.sv
